// ===== design/fobb_pkg.sv =====
// ----------------------------------------------------------------------------
// fobb_pkg: shared types and constants for the frustum box culling core
// Box transaction layout, fixed-point widths and plane register indexes.
// ----------------------------------------------------------------------------
package fobb_pkg;

  localparam int NUM_PLANES = 5;
  localparam int PLANE_W    = 64;
  localparam int NRM_W      = 12;  // signed Q1.10 component
  localparam int POS_W      = 28;  // signed Q19.8
  localparam int HALF_W     = 27;  // unsigned Q19.8
  localparam int AXIS_W     = 36;  // three packed Q1.10 components
  localparam int DIST_LSB   = 36;  // plane distance starts here
  localparam int INDEX_W    = 3;

  // derived arithmetic widths
  localparam int PAX_W  = 2 * NRM_W;          // one normal*axis product
  localparam int DOT_W  = PAX_W + 2;          // sum of three products
  localparam int ADOT_W = DOT_W - 1;          // magnitude of that sum
  localparam int PC_W   = NRM_W + POS_W;      // one normal*center product
  localparam int DSC_W  = POS_W + 10;         // distance scaled to 18 fraction bits
  localparam int S_W    = PC_W + 3;           // signed distance, 18 fraction bits
  localparam int EXT_W  = HALF_W + ADOT_W;    // one projected extent term
  localparam int E_W    = EXT_W + 2;          // projected extent, 28 fraction bits
  localparam int CMP_W  = E_W + 2;            // common compare width

  localparam int CELL_STAGES = 4;

  typedef enum logic [INDEX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_FAR    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;
    logic [HALF_W-1:0]       half_u;
    logic [HALF_W-1:0]       half_v;
    logic [HALF_W-1:0]       half_w;
    logic [AXIS_W-1:0]       axis_u;
    logic [AXIS_W-1:0]       axis_v;
    logic [AXIS_W-1:0]       axis_w;
  } box_t;

endpackage

// ===== design/fobb_cell.sv =====
// ----------------------------------------------------------------------------
// fobb_cell: one plane test of the culling chain
// Four-stage cell: products, dot sums, extent products, compare. The box and
// the running visible flag move on to the next cell with the result.
// ----------------------------------------------------------------------------
module fobb_cell
  import fobb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [PLANE_W-1:0] plane,
  input  logic               up_valid,
  input  box_t               up_box,
  input  logic               up_vis,
  output logic               up_ready,
  output logic               dn_valid,
  output box_t               dn_box,
  output logic               dn_vis,
  input  logic               dn_ready
);

  logic [CELL_STAGES-1:0] stage_valid;
  logic [CELL_STAGES-1:0] stage_ready;
  box_t                   box_q [CELL_STAGES];
  logic                   vis_q [CELL_STAGES];

  // stage payloads
  logic signed [PAX_W-1:0]  prod_ax [3][3];
  logic signed [PC_W-1:0]   prod_c  [3];
  logic [ADOT_W-1:0]        abs_dot [3];
  logic signed [S_W-1:0]    dist1;
  logic [EXT_W-1:0]         ext     [3];
  logic signed [S_W-1:0]    dist2;

  logic signed [NRM_W-1:0]  nrm [3];
  logic signed [DSC_W-1:0]  dist_scaled;

  logic signed [PAX_W-1:0]  prod_ax_next [3][3];
  logic signed [PC_W-1:0]   prod_c_next  [3];
  logic signed [DOT_W-1:0]  dot          [3];
  logic [ADOT_W-1:0]        abs_dot_next [3];
  logic signed [S_W-1:0]    dist1_next;
  logic [EXT_W-1:0]         ext_next     [3];
  logic [HALF_W-1:0]        half         [3];
  logic [AXIS_W-1:0]        axis         [3];
  logic signed [POS_W-1:0]  center       [3];
  logic [E_W-1:0]           extent;
  logic signed [CMP_W-1:0]  cmp_s;
  logic signed [CMP_W-1:0]  cmp_e;
  logic                     pass;

  assign nrm[0]      = $signed(plane[NRM_W-1:0]);
  assign nrm[1]      = $signed(plane[2*NRM_W-1:NRM_W]);
  assign nrm[2]      = $signed(plane[3*NRM_W-1:2*NRM_W]);
  assign dist_scaled = $signed({plane[PLANE_W-1:DIST_LSB], 10'd0});

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    stage_ready[CELL_STAGES-1] = !stage_valid[CELL_STAGES-1] || dn_ready;
    for (int k = CELL_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign up_ready = stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= up_valid;
      end
      for (int k = 1; k < CELL_STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // stage 0: normal times axes and center
  always_comb begin
    axis[0]   = up_box.axis_u;
    axis[1]   = up_box.axis_v;
    axis[2]   = up_box.axis_w;
    center[0] = up_box.center_x;
    center[1] = up_box.center_y;
    center[2] = up_box.center_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_ax_next[i][j] = nrm[j] * $signed(axis[i][j*NRM_W +: NRM_W]);
      end
      prod_c_next[i] = nrm[i] * center[i];
    end
  end

  // stage 1: dot sums, magnitudes and signed distance
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i] = DOT_W'(prod_ax[i][0]) + DOT_W'(prod_ax[i][1]) + DOT_W'(prod_ax[i][2]);
      abs_dot_next[i] = dot[i][DOT_W-1] ? ADOT_W'(-dot[i]) : ADOT_W'(dot[i]);
    end
    dist1_next = S_W'(prod_c[0]) + S_W'(prod_c[1]) + S_W'(prod_c[2])
               + S_W'(dist_scaled);
  end

  // stage 2: half extents times projected axes
  always_comb begin
    half[0] = box_q[1].half_u;
    half[1] = box_q[1].half_v;
    half[2] = box_q[1].half_w;
    for (int i = 0; i < 3; i++) begin
      ext_next[i] = EXT_W'(half[i]) * EXT_W'(abs_dot[i]);
    end
  end

  // stage 3: outside when s scaled to 28 fraction bits exceeds the extent
  always_comb begin
    extent = E_W'(ext[0]) + E_W'(ext[1]) + E_W'(ext[2]);
    cmp_s  = $signed({{(CMP_W - S_W - 10){dist2[S_W-1]}}, dist2, 10'd0});
    cmp_e  = $signed({{(CMP_W - E_W){1'b0}}, extent});
    pass   = cmp_s <= cmp_e;
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0] && up_valid) begin
      box_q[0]   <= up_box;
      vis_q[0]   <= up_vis;
      prod_ax    <= prod_ax_next;
      prod_c     <= prod_c_next;
    end
    if (stage_ready[1] && stage_valid[0]) begin
      box_q[1]   <= box_q[0];
      vis_q[1]   <= vis_q[0];
      abs_dot    <= abs_dot_next;
      dist1      <= dist1_next;
    end
    if (stage_ready[2] && stage_valid[1]) begin
      box_q[2]   <= box_q[1];
      vis_q[2]   <= vis_q[1];
      ext        <= ext_next;
      dist2      <= dist1;
    end
    if (stage_ready[3] && stage_valid[2]) begin
      box_q[3]   <= box_q[2];
      vis_q[3]   <= vis_q[2] & pass;
    end
  end

  assign dn_valid = stage_valid[CELL_STAGES-1];
  assign dn_box   = box_q[CELL_STAGES-1];
  assign dn_vis   = vis_q[CELL_STAGES-1];

endmodule

// ===== design/frustum_obb_cull_core.sv =====
// ----------------------------------------------------------------------------
// frustum_obb_cull_core: oriented box versus five frustum planes
// Holds the plane registers and a chain of plane test cells.
// ----------------------------------------------------------------------------
// usage:
//   box channel: box_valid with center, half extents and axes; a box
//   transaction completes when box_valid is high and box_stall is low
//   result channel: result_valid with visible; completes when result_valid
//   is high and result_stall is low
//   planes are loaded through write_en / write_index / write_data while the
//   core is idle; index 0..4 is left, right, bottom, top, far
//   the chain has five cells of four stages each, one per plane;
//   one box per cycle is taken while box_stall is low, since every
//   stage of every cell is pipelined
//   reset empties the chain and clears all planes to zero, which makes
//   every box visible until planes are loaded
//   when result_stall is high the last stage holds its result; stages behind
//   it keep filling empty slots, and box_stall rises only once the chain
//   is full
// ----------------------------------------------------------------------------
module frustum_obb_cull_core
  import fobb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write_en,
  input  logic [INDEX_W-1:0]      write_index,
  input  logic [PLANE_W-1:0]      write_data,
  input  logic                    box_valid,
  output logic                    box_stall,
  input  logic signed [POS_W-1:0] center_x,
  input  logic signed [POS_W-1:0] center_y,
  input  logic signed [POS_W-1:0] center_z,
  input  logic [HALF_W-1:0]       half_u,
  input  logic [HALF_W-1:0]       half_v,
  input  logic [HALF_W-1:0]       half_w,
  input  logic [AXIS_W-1:0]       axis_u,
  input  logic [AXIS_W-1:0]       axis_v,
  input  logic [AXIS_W-1:0]       axis_w,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    visible
);

  logic [PLANE_W-1:0] planes [NUM_PLANES];

  logic link_valid [NUM_PLANES+1];
  box_t link_box   [NUM_PLANES+1];
  logic link_vis   [NUM_PLANES+1];
  logic link_ready [NUM_PLANES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (write_en) begin
      case (write_index)
        REG_PLANE_LEFT:   planes[0] <= write_data;
        REG_PLANE_RIGHT:  planes[1] <= write_data;
        REG_PLANE_BOTTOM: planes[2] <= write_data;
        REG_PLANE_TOP:    planes[3] <= write_data;
        REG_PLANE_FAR:    planes[4] <= write_data;
        default: ;
      endcase
    end
  end

  assign link_valid[0]        = box_valid;
  assign link_box[0].center_x = center_x;
  assign link_box[0].center_y = center_y;
  assign link_box[0].center_z = center_z;
  assign link_box[0].half_u   = half_u;
  assign link_box[0].half_v   = half_v;
  assign link_box[0].half_w   = half_w;
  assign link_box[0].axis_u   = axis_u;
  assign link_box[0].axis_v   = axis_v;
  assign link_box[0].axis_w   = axis_w;
  assign link_vis[0]          = 1'b1;
  assign box_stall            = !link_ready[0];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    fobb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .plane    (planes[p]),
      .up_valid (link_valid[p]),
      .up_box   (link_box[p]),
      .up_vis   (link_vis[p]),
      .up_ready (link_ready[p]),
      .dn_valid (link_valid[p+1]),
      .dn_box   (link_box[p+1]),
      .dn_vis   (link_vis[p+1]),
      .dn_ready (link_ready[p+1])
    );
  end

  assign link_ready[NUM_PLANES] = !result_stall;
  assign result_valid           = link_valid[NUM_PLANES];
  assign visible                = link_vis[NUM_PLANES];

endmodule

// ===== test/tb_frustum_obb_cull_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frustum_obb_cull_core: self-checking bench for the frustum box cull core
// Loads plane sets while the core is idle and streams oriented boxes through
// it. Each box's visible bit is predicted with exact 64-bit math and compared
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_frustum_obb_cull_core;
  import fobb_pkg::*;

  localparam int     NRM_TOP      = 2**(NRM_W-1) - 1;
  localparam int     NRM_BOT      = -(2**(NRM_W-1));
  localparam int     ONE          = 2**(NRM_W-2);     // 1.0 in Q1.10
  localparam int     POS_TOP      = 2**(POS_W-1) - 1;
  localparam int     POS_BOT      = -(2**(POS_W-1));
  localparam int     HALF_TOP     = 2**HALF_W - 1;
  localparam longint FRAC_ALIGN   = 1 << 10;
  localparam int     SETTLE       = 2 * NUM_PLANES * CELL_STAGES;
  localparam int     RANDOM_BOXES = 850;
  localparam int     TIMEOUT_NS   = 1_000_000;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    write_en     = 1'b0;
  logic [INDEX_W-1:0]      write_index  = '0;
  logic [PLANE_W-1:0]      write_data   = '0;
  logic                    box_valid    = 1'b0;
  logic                    box_stall;
  logic signed [POS_W-1:0] center_x     = '0;
  logic signed [POS_W-1:0] center_y     = '0;
  logic signed [POS_W-1:0] center_z     = '0;
  logic [HALF_W-1:0]       half_u       = '0;
  logic [HALF_W-1:0]       half_v       = '0;
  logic [HALF_W-1:0]       half_w       = '0;
  logic [AXIS_W-1:0]       axis_u       = '0;
  logic [AXIS_W-1:0]       axis_v       = '0;
  logic [AXIS_W-1:0]       axis_w       = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic                    visible;

  logic [PLANE_W-1:0] plane_regs [NUM_PLANES];
  box_t               pending_boxes [$];
  bit                 expected_visible [$];
  box_t               box_on_bus;
  bit                 visible_want;
  int                 tx_wait;
  int                 rx_stall_left;
  bit                 tx_quiet;
  bit                 rx_quiet;
  int                 n_errors;
  int                 scene_scale;

  frustum_obb_cull_core DUT (
    .clk          (clk),
    .rst          (rst),
    .write_en     (write_en),
    .write_index  (write_index),
    .write_data   (write_data),
    .box_valid    (box_valid),
    .box_stall    (box_stall),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .half_u       (half_u),
    .half_v       (half_v),
    .half_w       (half_w),
    .axis_u       (axis_u),
    .axis_v       (axis_v),
    .axis_w       (axis_w),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .visible      (visible)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sext_field(logic [63:0] v, int w);
    longint t;
    t = longint'(v << (64 - w));
    return t >>> (64 - w);
  endfunction

  // exact cull test of one box against the current plane registers
  function automatic bit predict_visible(box_t b);
    longint            ctr [3];
    longint            hext [3];
    longint            ax [3][3];
    longint            nrm [3];
    logic [AXIS_W-1:0] axes [3];
    longint            dpl, sdist, ext, proj;
    bit                vis;
    int                p, i, k;
    vis     = 1'b1;
    ctr[0]  = sext_field(b.center_x, POS_W);
    ctr[1]  = sext_field(b.center_y, POS_W);
    ctr[2]  = sext_field(b.center_z, POS_W);
    hext[0] = longint'(b.half_u);
    hext[1] = longint'(b.half_v);
    hext[2] = longint'(b.half_w);
    axes[0] = b.axis_u;
    axes[1] = b.axis_v;
    axes[2] = b.axis_w;
    for (i = 0; i < 3; i++)
      for (k = 0; k < 3; k++)
        ax[i][k] = sext_field(axes[i] >> (NRM_W * k), NRM_W);
    for (p = 0; p < NUM_PLANES; p++) begin
      for (k = 0; k < 3; k++)
        nrm[k] = sext_field(plane_regs[p] >> (NRM_W * k), NRM_W);
      dpl = sext_field(plane_regs[p] >> DIST_LSB, POS_W);
      ext = 0;
      for (i = 0; i < 3; i++) begin
        proj = nrm[0] * ax[i][0] + nrm[1] * ax[i][1] + nrm[2] * ax[i][2];
        if (proj < 0) proj = -proj;
        ext += hext[i] * proj;
      end
      // bring n.c + d from 18 to 28 fraction bits to line up with the extent
      sdist = (nrm[0] * ctr[0] + nrm[1] * ctr[1] + nrm[2] * ctr[2]
               + dpl * FRAC_ALIGN) * FRAC_ALIGN;
      if (sdist - ext > 0) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic logic [AXIS_W-1:0] pack_vec(int x, int y, int z);
    return {z[NRM_W-1:0], y[NRM_W-1:0], x[NRM_W-1:0]};
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {d[POS_W-1:0], pack_vec(nx, ny, nz)};
  endfunction

  function automatic box_t mk_box(int cx, int cy, int cz, int hu, int hv, int hw,
                                  logic [AXIS_W-1:0] au, logic [AXIS_W-1:0] av,
                                  logic [AXIS_W-1:0] aw);
    box_t b;
    b.center_x = cx[POS_W-1:0];
    b.center_y = cy[POS_W-1:0];
    b.center_z = cz[POS_W-1:0];
    b.half_u   = hu[HALF_W-1:0];
    b.half_v   = hv[HALF_W-1:0];
    b.half_w   = hw[HALF_W-1:0];
    b.axis_u   = au;
    b.axis_v   = av;
    b.axis_w   = aw;
    return b;
  endfunction

  function automatic int rand_comp(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    int s;
    int slot;
    if ($urandom_range(0, 1) == 0)
      return pack_vec(rand_comp(ONE), rand_comp(ONE), rand_comp(ONE));
    s    = ($urandom_range(0, 1) == 0) ? ONE : -ONE;
    slot = $urandom_range(0, 2);
    if (slot == 0) return pack_vec(s, 0, 0);
    if (slot == 1) return pack_vec(0, s, 0);
    return pack_vec(0, 0, s);
  endfunction

  function automatic box_t random_box(int scale);
    box_t b;
    int   hmax;
    if ($urandom_range(0, 4) == 0) begin
      // raw bits across every field
      b.center_x = POS_W'($urandom);
      b.center_y = POS_W'($urandom);
      b.center_z = POS_W'($urandom);
      b.half_u   = HALF_W'($urandom);
      b.half_v   = HALF_W'($urandom);
      b.half_w   = HALF_W'($urandom);
      b.axis_u   = AXIS_W'({$urandom, $urandom});
      b.axis_v   = AXIS_W'({$urandom, $urandom});
      b.axis_w   = AXIS_W'({$urandom, $urandom});
      return b;
    end
    hmax = ($urandom_range(0, 3) == 0) ? 2 * scale : scale / 2;
    return mk_box(rand_comp(2 * scale), rand_comp(2 * scale), rand_comp(2 * scale),
                  $urandom_range(0, hmax), $urandom_range(0, hmax),
                  $urandom_range(0, hmax), pick_axis(), pick_axis(), pick_axis());
  endfunction

  // one register write; write_en stays high until end_writes
  task automatic load_plane(logic [INDEX_W-1:0] idx, logic [PLANE_W-1:0] data);
    @(posedge clk);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= data;
    if (idx < NUM_PLANES) plane_regs[idx] = data;
  endtask

  task automatic end_writes();
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_boxes.size() != 0 || box_valid || expected_visible.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_frustum(int w, int h, int f, int jit);
    load_plane(REG_PLANE_LEFT,
               pack_plane(-ONE + rand_comp(jit), rand_comp(jit), rand_comp(jit), -w));
    load_plane(REG_PLANE_RIGHT,
               pack_plane(ONE + rand_comp(jit), rand_comp(jit), rand_comp(jit), -w));
    load_plane(REG_PLANE_BOTTOM,
               pack_plane(rand_comp(jit), -ONE + rand_comp(jit), rand_comp(jit), -h));
    load_plane(REG_PLANE_TOP,
               pack_plane(rand_comp(jit), ONE + rand_comp(jit), rand_comp(jit), -h));
    load_plane(REG_PLANE_FAR,
               pack_plane(rand_comp(jit), rand_comp(jit), ONE + rand_comp(jit), -f));
  endtask

  task automatic load_scene(int scale);
    int sel;
    sel = $urandom_range(0, 5);
    if (sel <= 2) begin
      load_frustum($urandom_range(scale / 4, scale), $urandom_range(scale / 4, scale),
                   $urandom_range(scale / 2, 2 * scale), (sel == 0) ? 0 : 64);
    end else begin
      for (int i = 0; i < NUM_PLANES; i++)
        if (sel <= 4)
          load_plane(reg_index_t'(i), pack_plane(rand_comp(ONE), rand_comp(ONE),
                                                 rand_comp(ONE), rand_comp(scale)));
        else
          load_plane(reg_index_t'(i), {$urandom, $urandom});
    end
    if ($urandom_range(0, 3) == 0)
      load_plane(INDEX_W'($urandom_range(NUM_PLANES, 2**INDEX_W - 1)),
                 {$urandom, $urandom});
    end_writes();
  endtask

  // box sender
  always @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
      tx_wait   <= 0;
    end else begin
      if (box_valid && !box_stall)
        expected_visible.push_back(predict_visible(box_on_bus));
      if (!(box_valid && box_stall)) begin
        if (tx_wait != 0) begin
          box_valid <= 1'b0;
          tx_wait   <= tx_wait - 1;
        end else if (pending_boxes.size() != 0) begin
          box_on_bus = pending_boxes.pop_front();
          center_x  <= box_on_bus.center_x;
          center_y  <= box_on_bus.center_y;
          center_z  <= box_on_bus.center_z;
          half_u    <= box_on_bus.half_u;
          half_v    <= box_on_bus.half_v;
          half_w    <= box_on_bus.half_w;
          axis_u    <= box_on_bus.axis_u;
          axis_v    <= box_on_bus.axis_v;
          axis_w    <= box_on_bus.axis_w;
          box_valid <= 1'b1;
          tx_wait   <= draw_wait(tx_quiet);
        end else begin
          box_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      result_stall  <= 1'b0;
      rx_stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_visible.size() == 0) begin
          $display("%0t: result with no box pending, expected none actual visible=%0b",
                   $time, visible);
          n_errors++;
        end else begin
          visible_want = expected_visible.pop_front();
          if (visible !== visible_want) begin
            $display("%0t: visible mismatch, expected %0b actual %0b",
                     $time, visible_want, visible);
            n_errors++;
          end
        end
        rx_stall_left = draw_wait(rx_quiet);
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
      end
      result_stall <= (rx_stall_left != 0);
    end
  end

  initial begin
    int n_random;
    int chunk;
    int w, h, f;
    n_errors = 0;
    n_random = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) plane_regs[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // spare indexes must not land on a plane; all-zero planes pass every box
    for (int i = NUM_PLANES; i < 2**INDEX_W; i++)
      load_plane(INDEX_W'(i), pack_plane(0, 0, 0, POS_TOP));
    end_writes();
    pending_boxes.push_back(mk_box(0, 0, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(POS_TOP, POS_TOP, POS_TOP, HALF_TOP, HALF_TOP, HALF_TOP,
                                   pack_vec(NRM_TOP, NRM_TOP, NRM_TOP),
                                   pack_vec(NRM_TOP, NRM_TOP, NRM_TOP),
                                   pack_vec(NRM_TOP, NRM_TOP, NRM_TOP)));
    pending_boxes.push_back(mk_box(POS_BOT, POS_BOT, POS_BOT, 0, 0, 0,
                                   pack_vec(NRM_BOT, NRM_BOT, NRM_BOT),
                                   pack_vec(NRM_BOT, NRM_BOT, NRM_BOT),
                                   pack_vec(NRM_BOT, NRM_BOT, NRM_BOT)));
    pending_boxes.push_back('1);
    wait_drained();

    // extreme normals and distances
    tx_quiet = 1'b1;
    load_plane(REG_PLANE_LEFT,   pack_plane(NRM_BOT, NRM_BOT, NRM_BOT, POS_BOT));
    load_plane(REG_PLANE_RIGHT,  pack_plane(NRM_TOP, NRM_TOP, NRM_TOP, POS_BOT));
    load_plane(REG_PLANE_BOTTOM, pack_plane(NRM_TOP, NRM_BOT, NRM_TOP, POS_BOT));
    load_plane(REG_PLANE_TOP,    pack_plane(NRM_BOT, NRM_TOP, NRM_BOT, POS_TOP));
    load_plane(REG_PLANE_FAR,    pack_plane(0, 0, ONE, POS_BOT));
    end_writes();
    pending_boxes.push_back(mk_box(0, 0, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(POS_TOP, POS_TOP, POS_TOP, HALF_TOP, HALF_TOP, HALF_TOP,
                                   pack_vec(NRM_TOP, NRM_TOP, NRM_TOP),
                                   pack_vec(NRM_BOT, NRM_BOT, NRM_BOT),
                                   pack_vec(NRM_TOP, NRM_BOT, NRM_TOP)));
    pending_boxes.push_back(mk_box(POS_BOT, POS_BOT, POS_BOT, HALF_TOP, 0, HALF_TOP,
                                   pack_vec(NRM_BOT, NRM_BOT, NRM_BOT), '0,
                                   pack_vec(NRM_BOT, NRM_TOP, NRM_BOT)));
    pending_boxes.push_back(mk_box(POS_TOP, POS_BOT, POS_TOP, 0, HALF_TOP, 0, '0,
                                   pack_vec(NRM_TOP, NRM_TOP, NRM_TOP), '0));
    pending_boxes.push_back(mk_box(POS_BOT, POS_TOP, POS_BOT, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back('1);
    wait_drained();

    // plain axis-aligned frustum: one box per plane outside, straddles, boundary
    tx_quiet = 1'b0;
    rx_quiet = 1'b1;
    w = 16384;
    h = 8192;
    f = 65536;
    load_frustum(w, h, f, 0);
    end_writes();
    pending_boxes.push_back(mk_box(0, 0, 0, 256, 256, 256, pack_vec(ONE, 0, 0),
                                   pack_vec(0, ONE, 0), pack_vec(0, 0, ONE)));
    pending_boxes.push_back(mk_box(-2 * w, 0, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(-2 * w, 0, 0, 2 * w, 0, 0, pack_vec(ONE, 0, 0),
                                   pack_vec(0, ONE, 0), pack_vec(0, 0, ONE)));
    pending_boxes.push_back(mk_box(2 * w, 0, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(0, -2 * h, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(0, 2 * h, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(0, 0, 2 * f, 0, 0, 0, '0, '0, '0));
    // far behind the camera stays visible since there is no near plane
    pending_boxes.push_back(mk_box(0, 0, POS_BOT, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(2 * w, 0, 0, w + w / 2, w, 0,
                                   pack_vec(NRM_TOP, NRM_TOP, 0),
                                   pack_vec(NRM_BOT, 0, NRM_TOP), '0));
    // exactly on the left plane passes, one lsb further out does not
    pending_boxes.push_back(mk_box(-w, 0, 0, 0, 0, 0, '0, '0, '0));
    pending_boxes.push_back(mk_box(-w - 1, 0, 0, 0, 0, 0, '0, '0, '0));
    wait_drained();

    // random scenes; every chunk starts from an empty pipeline
    while (n_random < RANDOM_BOXES) begin
      wait_drained();
      scene_scale = 1 << $urandom_range(8, 20);
      if ($urandom_range(0, 3) != 0) load_scene(scene_scale);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      chunk = $urandom_range(40, 120);
      if (chunk > RANDOM_BOXES - n_random) chunk = RANDOM_BOXES - n_random;
      for (int i = 0; i < chunk; i++)
        pending_boxes.push_back(random_box(scene_scale));
      n_random += chunk;
    end
    wait_drained();

    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/fobb_pkg.sv
design/fobb_cell.sv
design/frustum_obb_cull_core.sv
test/tb_frustum_obb_cull_core.sv
